[hdl/lpmt_pkg.sv]
// Package for the longest prefix match table.
// Word types, controller/datapath command and status, code constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpmt_pkg;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] RSP_HIT     = 2'd0;
    localparam logic [1:0] RSP_MISS    = 2'd1;
    localparam logic [1:0] RSP_FULL    = 2'd2;
    localparam logic [1:0] RSP_BAD_LEN = 2'd3;

    localparam logic [7:0]  LEN_MAX_V4 = 8'd32;
    localparam logic [7:0]  LEN_MAX_V6 = 8'd128;
    localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  operation;
        logic        is_ipv6;
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [7:0]  prefix_length;
        logic [23:0] network_id;
        logic [31:0] entry_data;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] result_value;
    } t_rsp;

    typedef struct packed {
        logic         valid;
        logic         is_v6;
        logic [23:0]  network;
        logic [127:0] prefix;
        logic [7:0]   length;
        logic [31:0]  value;
    } t_row;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic clear;
        logic read;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

[hdl/lpmt_req_if.sv]
// Request channel interface: valid/ready plus one request word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface lpmt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic        is_ipv6;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [7:0]  prefix_length;
    logic [23:0] network_id;
    logic [31:0] entry_data;

    modport source (
        output valid, operation, is_ipv6, address_high, address_low,
               prefix_length, network_id, entry_data,
        input  ready
    );
    modport sink (
        input  valid, operation, is_ipv6, address_high, address_low,
               prefix_length, network_id, entry_data,
        output ready
    );
endinterface

`default_nettype wire

[hdl/lpmt_rsp_if.sv]
// Response channel interface: valid/ready plus one response word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface lpmt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        found;
    logic [31:0] result_value;

    modport source (output valid, status, found, result_value, input ready);
    modport sink   (input  valid, status, found, result_value, output ready);
endinterface

`default_nettype wire

[hdl/longest_prefix_match_table.sv]
// Longest prefix match table for IPv4/IPv6 prefixes keyed by network id.
// Request channel i_req (sink): one word per lookup, add or delete.
// Response channel o_rsp (source): exactly one word per request, in order.
// Each request scans every slot through one compare unit fed by a single
// read port of the slot memory; one slot per cycle.
// After acceptance the scan state reads every slot, then the finish state
// registers the response; no new request is taken until that finish is done.
// The response sits in an output register, so the next request is taken
// while the last response waits; if the receiver still stalls at the end
// of the next scan, the table holds that result until the register frees.
// Reset: a clearing pass writes every slot invalid, one slot a cycle,
// with i_req.ready low.
// Add masks the address to its length and returns the previous value;
// delete returns the removed value; bad length and table full are flagged.
// Depends on lpmt_pkg, lpmt_req_if, lpmt_rsp_if, lpmt_ctrl, lpmt_datapath.
`timescale 1ns / 1ps
`default_nettype none

module longest_prefix_match_table
    import lpmt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    localparam int AW = $clog2(TABLE_ENTRIES)
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lpmt_req_if.sink    i_req,
    lpmt_rsp_if.source  o_rsp
);

    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [AW-1:0] w_addr;
    t_req          w_req;
    t_rsp          w_rsp;
    logic          w_out_valid;

    assign w_req.operation     = i_req.operation;
    assign w_req.is_ipv6       = i_req.is_ipv6;
    assign w_req.address_high  = i_req.address_high;
    assign w_req.address_low   = i_req.address_low;
    assign w_req.prefix_length = i_req.prefix_length;
    assign w_req.network_id    = i_req.network_id;
    assign w_req.entry_data    = i_req.entry_data;
    assign i_req.ready         = w_cmd.in_ready;

    lpmt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_addr     (w_addr)
    );

    lpmt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_addr      (w_addr),
        .i_req       (w_req),
        .i_out_ready (o_rsp.ready),
        .o_sts       (w_sts),
        .o_out_valid (w_out_valid),
        .o_rsp       (w_rsp)
    );

    assign o_rsp.valid        = w_out_valid;
    assign o_rsp.status       = w_rsp.status;
    assign o_rsp.found        = w_rsp.found;
    assign o_rsp.result_value = w_rsp.result_value;

endmodule

`default_nettype wire

[hdl/lpmt_ctrl.sv]
// Controller for the prefix table: clearing pass, slot scan, finish.
// Depends on lpmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpmt_ctrl
    import lpmt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    localparam int AW = $clog2(TABLE_ENTRIES),
    localparam int IW = $clog2(TABLE_ENTRIES + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire t_sts          i_sts,
    output t_cmd               o_cmd,
    output logic [AW-1:0]      o_addr
);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_idx       = r_idx + IW'(1);
                if (r_idx == IW'(TABLE_ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_idx = r_idx + IW'(1);
                if (r_idx == IW'(TABLE_ENTRIES)) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.read = 1'b1;
                end
            end
            ST_FINISH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_addr = r_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    a_load_to_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ST_SCAN)
        else $error("load did not start a scan");

    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_idx == IW'(TABLE_ENTRIES)) |=> r_state == ST_FINISH)
        else $error("scan overran the table");

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_state == ST_IDLE && o_cmd.in_ready))
        else $error("finish did not return to idle");

    a_no_rd_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.read && (o_cmd.finish || o_cmd.clear || o_cmd.in_ready)))
        else $error("read issued outside scan");

endmodule

`default_nettype wire

[hdl/lpmt_datapath.sv]
// Datapath for the prefix table: slot memory, key and prefix compare,
// scan result registers and the response register. Depends on lpmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpmt_datapath
    import lpmt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    localparam int AW = $clog2(TABLE_ENTRIES)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cmd          i_cmd,
    input  wire logic [AW-1:0] i_addr,
    input  wire t_req          i_req,
    input  wire logic          i_out_ready,
    output t_sts               o_sts,
    output logic               o_out_valid,
    output t_rsp               o_rsp
);

    function automatic logic [127:0] prefix_mask(input logic v6, input logic [7:0] len);
        logic [127:0] m;
        logic [31:0]  m4;
        m4 = ~(32'hFFFF_FFFF >> len);
        if (v6) begin
            m = ~({128{1'b1}} >> len);
        end else begin
            m = {96'b0, m4};
        end
        return m;
    endfunction

    t_row mem [TABLE_ENTRIES];

    logic [1:0]    r_op;
    logic          r_v6;
    logic [127:0]  r_addr;
    logic [7:0]    r_len;
    logic [23:0]   r_net;
    logic [31:0]   r_data;
    logic          r_bad;

    t_row          r_rd_row;
    logic [AW-1:0] r_rd_idx;
    logic          r_rd_vld;

    logic          r_hit_found, r_free_found, r_best_found;
    logic [AW-1:0] r_hit_idx, r_free_idx;
    logic [31:0]   r_hit_val, r_best_val;
    logic [7:0]    r_best_len;

    logic          r_out_valid;
    t_rsp          r_rsp;

    logic [127:0]  w_key;
    logic [7:0]    w_max_len;
    logic          w_key_match, w_lpm_match, w_bad;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_row          w_wrow;
    t_rsp          w_rsp;

    assign w_key     = r_addr & prefix_mask(r_v6, r_len);
    assign w_max_len = r_v6 ? LEN_MAX_V6 : LEN_MAX_V4;

    always_comb begin
        w_bad = 1'b0;
        if (i_req.operation inside {OP_ADD, OP_DELETE}) begin
            w_bad = i_req.prefix_length > (i_req.is_ipv6 ? LEN_MAX_V6 : LEN_MAX_V4);
        end
    end

    assign w_key_match = r_rd_row.valid && (r_rd_row.is_v6 == r_v6)
                      && (r_rd_row.network == r_net) && (r_rd_row.length == r_len)
                      && (r_rd_row.prefix == w_key);

    assign w_lpm_match = r_rd_row.valid && (r_rd_row.is_v6 == r_v6)
                      && (r_rd_row.network == r_net) && (r_rd_row.length <= w_max_len)
                      && ((r_addr & prefix_mask(r_v6, r_rd_row.length)) == r_rd_row.prefix)
                      && (!r_best_found || (r_rd_row.length > r_best_len));

    // write port and response
    always_comb begin
        w_wrow.valid   = 1'b1;
        w_wrow.is_v6   = r_v6;
        w_wrow.network = r_net;
        w_wrow.prefix  = w_key;
        w_wrow.length  = r_len;
        w_wrow.value   = r_data;
        w_we           = 1'b0;
        w_waddr        = r_hit_idx;
        w_rsp.status       = RSP_MISS;
        w_rsp.found        = 1'b0;
        w_rsp.result_value = ALL_ONES32;
        if (i_cmd.clear) begin
            w_we         = 1'b1;
            w_waddr      = i_addr;
            w_wrow.valid = 1'b0;
        end else if (r_bad) begin
            w_rsp.status = RSP_BAD_LEN;
        end else begin
            case (r_op)
                OP_ADD: begin
                    if (r_hit_found) begin
                        w_we               = i_cmd.finish;
                        w_rsp.status       = RSP_HIT;
                        w_rsp.found        = 1'b1;
                        w_rsp.result_value = r_hit_val;
                    end else if (r_free_found) begin
                        w_we         = i_cmd.finish;
                        w_waddr      = r_free_idx;
                        w_rsp.status = RSP_HIT;
                    end else begin
                        w_rsp.status = RSP_FULL;
                    end
                end
                OP_DELETE: begin
                    w_wrow.valid = 1'b0;
                    if (r_hit_found) begin
                        w_we               = i_cmd.finish;
                        w_rsp.status       = RSP_HIT;
                        w_rsp.found        = 1'b1;
                        w_rsp.result_value = r_hit_val;
                    end
                end
                default: begin
                    if (r_best_found) begin
                        w_rsp.status       = RSP_HIT;
                        w_rsp.found        = 1'b1;
                        w_rsp.result_value = r_best_val;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wrow;
        end
        if (i_cmd.read) begin
            r_rd_row <= mem[i_addr];
            r_rd_idx <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_req.operation;
            r_v6   <= i_req.is_ipv6;
            r_addr <= i_req.is_ipv6 ? {i_req.address_high, i_req.address_low}
                                    : {96'b0, i_req.address_low[31:0]};
            r_len  <= i_req.prefix_length;
            r_net  <= i_req.network_id;
            r_data <= i_req.entry_data;
            r_bad  <= w_bad;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_best_found <= 1'b0;
        end else if (r_rd_vld) begin
            if (w_key_match && !r_hit_found) begin
                r_hit_found <= 1'b1;
                r_hit_idx   <= r_rd_idx;
                r_hit_val   <= r_rd_row.value;
            end
            if (!r_rd_row.valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_rd_idx;
            end
            if (w_lpm_match) begin
                r_best_found <= 1'b1;
                r_best_len   <= r_rd_row.length;
                r_best_val   <= r_rd_row.value;
            end
        end
        if (i_cmd.finish) begin
            r_rsp <= w_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.read;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_rsp          = r_rsp;

endmodule

`default_nettype wire
